>>> rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_done;
        logic       error;
    } t_out_item;

    // Results produced by one input transaction, up to three bytes.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  b0;
        t_out_item  b1;
        t_out_item  b2;
    } t_push;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_BSL   = 8'h5C;
    localparam logic [7:0]  CH_N     = 8'h6E;
    localparam logic [7:0]  CH_T     = 8'h74;
    localparam logic [7:0]  CH_R     = 8'h72;
    localparam logic [7:0]  CH_B     = 8'h62;
    localparam logic [7:0]  CH_F     = 8'h66;
    localparam logic [7:0]  CH_U     = 8'h75;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [5:0]  UTF8_MASK  = 6'h3F;
    localparam logic [15:0] CP_ONE_MAX = 16'h0080;
    localparam logic [15:0] CP_TWO_MAX = 16'h0800;

    localparam logic [1:0]  HEX_LAST  = 2'd3;
    localparam logic [2:0]  Q_DEPTH   = 3'd4;
    localparam logic [2:0]  Q_ACC_MAX = 3'd1;

endpackage

>>> rtl/json_string_unescape_utf8.sv
// Each result byte is registered in the result queue before it appears on the output.
// Throughput: one input byte per cycle while o_in_stall is low; a \u escape yielding three
// UTF-8 bytes can stall the input while the four-entry result queue drains.
// Input stall is set whenever the queue holds two or more bytes.
// Reset (synchronous, active low) returns to waiting for an opening quote, queue empty.
module json_string_unescape_utf8 import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic  accept;
    t_push push;

    assign accept = i_in_valid && !o_in_stall;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push)
    );

    jsu_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .o_full    (o_in_stall),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_data)
    );

endmodule

>>> rtl/jsu_decode.sv
// Escape decoder: parse state and per-byte result generation.
module jsu_decode import jsu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_cp, n_cp;
    logic [3:0]  hv;
    logic [15:0] cp_full;
    logic [7:0]  c;

    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [3:0] v;
        v = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
        else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h57);
        else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h37);
        return v;
    endfunction

    function automatic t_out_item mk(input logic [7:0] b, input logic d, input logic e);
        t_out_item o;
        o.out_byte    = b;
        o.string_done = d;
        o.error       = e;
        return o;
    endfunction

    assign c       = i_item.data_byte;
    assign hv      = hex_value(c);
    assign cp_full = {r_cp[11:0], hv};

    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_cp   = r_cp;
        o_push = '0;
        if (i_item.text_end) begin
            n_mode       = MODE_IDLE;
            n_hex        = '0;
            n_cp         = '0;
            o_push.count = 2'd1;
            o_push.b0    = mk(8'h00, 1'b0, 1'b1);
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    if (c == CH_QUOTE) begin
                        n_mode = MODE_STR;
                    end else begin
                        o_push.count = 2'd1;
                        o_push.b0    = mk(8'h00, 1'b0, 1'b1);
                    end
                end
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        n_mode       = MODE_IDLE;
                        o_push.count = 2'd1;
                        o_push.b0    = mk(8'h00, 1'b1, 1'b0);
                    end else if (c == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end else begin
                        o_push.count = 2'd1;
                        o_push.b0    = mk(c, 1'b0, 1'b0);
                    end
                end
                MODE_ESC: begin
                    if (c == CH_U) begin
                        n_mode = MODE_HEX;
                        n_hex  = '0;
                        n_cp   = '0;
                    end else begin
                        n_mode       = MODE_STR;
                        o_push.count = 2'd1;
                        case (c)
                            CH_N:    o_push.b0 = mk(8'h0A, 1'b0, 1'b0);
                            CH_T:    o_push.b0 = mk(8'h09, 1'b0, 1'b0);
                            CH_R:    o_push.b0 = mk(8'h0D, 1'b0, 1'b0);
                            CH_B:    o_push.b0 = mk(8'h08, 1'b0, 1'b0);
                            CH_F:    o_push.b0 = mk(8'h0C, 1'b0, 1'b0);
                            default: o_push.b0 = mk(c, 1'b0, 1'b0);
                        endcase
                    end
                end
                MODE_HEX: begin
                    if (r_hex != HEX_LAST) begin
                        n_cp  = cp_full;
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_mode = MODE_STR;
                        n_hex  = '0;
                        n_cp   = '0;
                        if (cp_full < CP_ONE_MAX) begin
                            o_push.count = 2'd1;
                            o_push.b0    = mk(cp_full[7:0], 1'b0, 1'b0);
                        end else if (cp_full < CP_TWO_MAX) begin
                            o_push.count = 2'd2;
                            o_push.b0    = mk(UTF8_LEAD2 | {3'b000, cp_full[10:6]},
                                              1'b0, 1'b0);
                            o_push.b1    = mk(UTF8_CONT | {2'b00, cp_full[5:0] & UTF8_MASK},
                                              1'b0, 1'b0);
                        end else begin
                            o_push.count = 2'd3;
                            o_push.b0    = mk(UTF8_LEAD3 | {4'b0000, cp_full[15:12]},
                                              1'b0, 1'b0);
                            o_push.b1    = mk(UTF8_CONT | {2'b00, cp_full[11:6] & UTF8_MASK},
                                              1'b0, 1'b0);
                            o_push.b2    = mk(UTF8_CONT | {2'b00, cp_full[5:0] & UTF8_MASK},
                                              1'b0, 1'b0);
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    n_hex  = '0;
                    n_cp   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_hex  <= '0;
            r_cp   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cp   <= n_cp;
        end
    end

endmodule

>>> rtl/jsu_outq.sv
// Four-entry result queue: takes up to three bytes per transaction, sends one per cycle unless stalled.
module jsu_outq import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_en,
    input  t_push     i_push,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_out_item  r_q [4];
    t_out_item  n_q [4];
    logic [2:0] r_cnt, n_cnt;
    logic [2:0] base;
    logic [2:0] add;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_q[0];
    assign pop     = o_valid && !i_stall;
    // Room for a worst-case three-byte transaction, decided from registered count only.
    assign o_full  = (r_cnt > Q_ACC_MAX);
    assign base    = r_cnt - {2'b00, pop};
    assign add     = i_push_en ? {1'b0, i_push.count} : 3'd0;
    assign n_cnt   = base + add;

    always_comb begin
        logic [2:0] off;
        for (int i = 0; i < 4; i++) begin
            if (pop && i < 3) n_q[i] = r_q[i + 1];
            else              n_q[i] = r_q[i];
            off = 3'(i) - base;
            if (3'(i) >= base && off < add) begin
                case (off)
                    3'd0:    n_q[i] = i_push.b0;
                    3'd1:    n_q[i] = i_push.b1;
                    default: n_q[i] = i_push.b2;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= (n_cnt > Q_DEPTH) ? Q_DEPTH : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule
